/* hw/rtl/pidw_pkg.sv */
// Package for the windowed PID velocity controller.
// Request/response payload types, stage tags, CSR map and fixed widths.
// No dependencies.
package pidw_pkg;

   localparam int FRAC_W   = 12;
   localparam int POS_W    = 16;
   localparam int VEL_W    = 16;
   localparam int FLOOR_W  = 4;
   localparam int DIST_W   = 16;
   localparam int MAG_W    = 13;
   localparam int ERR_W    = 18;
   localparam int DELTA_W  = 19;
   localparam int GAIN_W   = 24;
   localparam int ARRIVE_W = 12;
   localparam int STOP_W   = 15;
   localparam int POWER_W  = 32;

   localparam logic [DIST_W-1:0] FULL_SPEED_DIST = 16'd2048;
   localparam logic [MAG_W-1:0]  FULL_SPEED     = 13'd4096;

   localparam logic signed [POWER_W-1:0] POWER_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [POWER_W-1:0] POWER_MIN = 32'sh8000_0000;

   // request modes
   localparam logic MODE_RESTART = 1'b0;
   localparam logic MODE_TICK    = 1'b1;

   // CSR map, register i at byte address 4*i
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic [CSR_IDX_W-1:0] REG_ARRIVE_DIST = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_STOP_VEL    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_GAIN_PROP   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_GAIN_INTEG  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_GAIN_DERIV  = 3'd4;

   localparam logic [ARRIVE_W-1:0] ARRIVE_RESET     = 12'd41;
   localparam logic [STOP_W-1:0]   STOP_RESET       = 15'd4;
   localparam logic [GAIN_W-1:0]   GAIN_PROP_RESET  = 24'd20480;
   localparam logic [GAIN_W-1:0]   GAIN_INTEG_RESET = 24'd12;
   localparam logic [GAIN_W-1:0]   GAIN_DERIV_RESET = 24'd12288000;

   // response queue
   localparam int FIFO_DEPTH = 8;
   localparam int FIFO_PTR_W = 3;
   localparam int OCC_W      = 4;

   typedef struct packed {
      logic                      mode;
      logic [POS_W-1:0]          floor_pos;
      logic signed [VEL_W-1:0]   velocity;
      logic [FLOOR_W-1:0]        target_floor;
   } req_type;

   typedef struct packed {
      logic signed [POWER_W-1:0] motor_power;
      logic                      brake;
      logic                      arrived;
   } rsp_type;

   // what the arithmetic pipe carries beside the numbers
   typedef struct packed {
      logic pass;      // PID tick, power goes out
      logic brake;
      logic arrived;
   } pidw_tag_type;

endpackage

/* hw/rtl/pidw_cell.sv */
// One slot of the error window shift line.
// Depends on pidw_pkg.
module pidw_cell
   import pidw_pkg::*;
(
   input  logic                    clock,
   input  logic                    shift_en,
   input  logic signed [ERR_W-1:0] d_in,
   output logic signed [ERR_W-1:0] q_out
);

   logic signed [ERR_W-1:0] win_ff;
   logic signed [ERR_W-1:0] win_in;

   assign win_in = shift_en ? d_in : win_ff;

   always_ff @(posedge clock) begin
      win_ff <= win_in;
   end

   assign q_out = win_ff;

endmodule

/* hw/rtl/pidw_mac.sv */
// PID multiply-accumulate pipe: three products, sum, floor to Q.12, saturate.
// Depends on pidw_pkg.
module pidw_mac
   import pidw_pkg::*;
#(
   parameter int SUM_W = 26
)
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      in_valid,
   input  pidw_tag_type              in_tag,
   input  logic signed [ERR_W-1:0]   in_err,
   input  logic signed [SUM_W-1:0]   in_sum,
   input  logic signed [DELTA_W-1:0] in_delta,
   input  logic [GAIN_W-1:0]         gain_prop,
   input  logic [GAIN_W-1:0]         gain_integ,
   input  logic [GAIN_W-1:0]         gain_deriv,
   output logic                      out_valid,
   output rsp_type                   out_rsp
);

   localparam int PP_W  = GAIN_W + 1 + ERR_W;
   localparam int PI_W  = GAIN_W + 1 + SUM_W;
   localparam int PD_W  = GAIN_W + 1 + DELTA_W;
   localparam int ACC_W = PI_W + 2;

   // stage a: products
   logic                     a_valid_ff;
   pidw_tag_type             a_tag_ff;
   logic signed [PP_W-1:0]   pp_ff, pp_in;
   logic signed [PI_W-1:0]   pi_ff, pi_in;
   logic signed [PD_W-1:0]   pd_ff, pd_in;

   assign pp_in = $signed({1'b0, gain_prop}) * in_err;
   assign pi_in = $signed({1'b0, gain_integ}) * in_sum;
   assign pd_in = $signed({1'b0, gain_deriv}) * in_delta;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= in_valid;
      end
      a_tag_ff <= in_tag;
      pp_ff    <= pp_in;
      pi_ff    <= pi_in;
      pd_ff    <= pd_in;
   end

   // stage b: sum in Q.24
   logic                     b_valid_ff;
   pidw_tag_type             b_tag_ff;
   logic signed [ACC_W-1:0]  acc_ff, acc_in;

   assign acc_in = ACC_W'(pp_ff) + ACC_W'(pi_ff) + ACC_W'(pd_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else begin
         b_valid_ff <= a_valid_ff;
      end
      b_tag_ff <= a_tag_ff;
      acc_ff   <= acc_in;
   end

   // stage c: arithmetic shift floors, then clamp to 32 bits
   logic signed [ACC_W-1:0]   acc_sh;
   logic [ACC_W-POWER_W:0]    acc_hi;
   logic                      pos_ovf, neg_ovf;
   logic signed [POWER_W-1:0] sat_pw;
   logic                      out_valid_ff;
   rsp_type                   out_rsp_ff, out_rsp_in;

   assign acc_sh  = acc_ff >>> FRAC_W;
   assign acc_hi  = acc_sh[ACC_W-1:POWER_W-1];
   assign pos_ovf = !acc_sh[ACC_W-1] && (|acc_hi);
   assign neg_ovf = acc_sh[ACC_W-1] && !(&acc_hi);

   always_comb begin
      if (pos_ovf) begin
         sat_pw = POWER_MAX;
      end else if (neg_ovf) begin
         sat_pw = POWER_MIN;
      end else begin
         sat_pw = acc_sh[POWER_W-1:0];
      end
      out_rsp_in.motor_power = b_tag_ff.pass ? sat_pw : '0;
      out_rsp_in.brake       = b_tag_ff.brake;
      out_rsp_in.arrived     = b_tag_ff.arrived;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= b_valid_ff;
      end
      out_rsp_ff <= out_rsp_in;
   end

   assign out_valid = out_valid_ff;
   assign out_rsp   = out_rsp_ff;

endmodule

/* hw/rtl/windowed_pid_velocity_controller_unit.sv */
// Top level of the windowed PID velocity controller.
// Depends on pidw_pkg, pidw_cell (error window) and pidw_mac (PID arithmetic).
//
//   channel | ports               | moves                           | accepted when
//   --------+---------------------+---------------------------------+----------------------
//   req     | req_valid/ready     | request: mode, pos, vel, target | req_valid & req_ready
//   rsp     | rsp_valid/ready     | power, brake, arrived           | rsp_valid & rsp_ready
//   csr     | psel/penable/pwrite | register write / read           | psel&penable&pwrite
//
// One request per cycle sustained while req_ready is high. A request passes
// three front stages (distance, error, window update) and three in the
// multiply-accumulate pipe, then the response queue, before its response handshake.
// req_ready drops once 8 requests are in flight or queued; that bound is the
// depth of the response queue, so the pipe itself never stalls.
// Reset is synchronous; no clearing pass: window slots are read only once the
// fill count shows them written since the last restart.
module windowed_pid_velocity_controller_unit
   import pidw_pkg::*;
#(
   parameter int WINDOW_LEN = 200
)
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  req_type               req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rsp_type               rsp_data,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   localparam int FILL_W = $clog2(WINDOW_LEN + 1);
   localparam int SUM_W  = ERR_W + FILL_W;

   // ------------------------------------------------------------------
   // CSRs
   // ------------------------------------------------------------------
   logic [ARRIVE_W-1:0] arrive_ff;
   logic [STOP_W-1:0]   stop_ff;
   logic [GAIN_W-1:0]   kp_ff, ki_ff, kd_ff;
   logic                csr_write;
   logic [CSR_IDX_W-1:0] csr_idx;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;
   assign csr_idx   = paddr[CSR_ADDR_W-1:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         arrive_ff <= ARRIVE_RESET;
         stop_ff   <= STOP_RESET;
         kp_ff     <= GAIN_PROP_RESET;
         ki_ff     <= GAIN_INTEG_RESET;
         kd_ff     <= GAIN_DERIV_RESET;
      end else if (csr_write) begin
         case (csr_idx)
            REG_ARRIVE_DIST: arrive_ff <= pwdata[ARRIVE_W-1:0];
            REG_STOP_VEL:    stop_ff   <= pwdata[STOP_W-1:0];
            REG_GAIN_PROP:   kp_ff     <= pwdata[GAIN_W-1:0];
            REG_GAIN_INTEG:  ki_ff     <= pwdata[GAIN_W-1:0];
            REG_GAIN_DERIV:  kd_ff     <= pwdata[GAIN_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_idx)
         REG_ARRIVE_DIST: prdata = CSR_DATA_W'(arrive_ff);
         REG_STOP_VEL:    prdata = CSR_DATA_W'(stop_ff);
         REG_GAIN_PROP:   prdata = CSR_DATA_W'(kp_ff);
         REG_GAIN_INTEG:  prdata = CSR_DATA_W'(ki_ff);
         REG_GAIN_DERIV:  prdata = CSR_DATA_W'(kd_ff);
         default:         prdata = '0;
      endcase
   end

   // ------------------------------------------------------------------
   // Flow control: count requests in flight plus queued responses
   // ------------------------------------------------------------------
   logic             req_fire, rsp_fire;
   logic [OCC_W-1:0] occ_ff, occ_in;

   assign req_ready = occ_ff < OCC_W'(FIFO_DEPTH);
   assign req_fire  = req_valid && req_ready;
   assign rsp_fire  = rsp_valid && rsp_ready;
   assign occ_in    = occ_ff + OCC_W'(req_fire) - OCC_W'(rsp_fire);

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff <= '0;
      end else begin
         occ_ff <= occ_in;
      end
   end

   // ------------------------------------------------------------------
   // Stage 1: distance to target and direction
   // ------------------------------------------------------------------
   logic signed [POS_W:0]   diff;
   logic [DIST_W-1:0]       car_dist;
   logic                    s1_valid_ff;
   logic                    s1_mode_ff;
   logic signed [VEL_W-1:0] s1_vel_ff;
   logic [DIST_W-1:0]       s1_dist_ff;
   logic                    s1_below_ff;     // car is under the target

   assign diff = $signed({1'b0, req_data.floor_pos})
               - $signed({1'b0, req_data.target_floor, {FRAC_W{1'b0}}});
   assign car_dist = diff[POS_W] ? DIST_W'(-diff) : diff[DIST_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= req_fire;
      end
      s1_mode_ff  <= req_data.mode;
      s1_vel_ff   <= req_data.velocity;
      s1_dist_ff  <= car_dist;
      s1_below_ff <= diff[POS_W];
   end

   // ------------------------------------------------------------------
   // Stage 2: arrival test and speed error
   // ------------------------------------------------------------------
   logic                    arrive;
   logic [MAG_W-1:0]        mag;
   logic signed [ERR_W-1:0] desired, err;
   logic                    s2_valid_ff;
   logic                    s2_mode_ff;
   logic                    s2_arrive_ff;
   logic signed [ERR_W-1:0] s2_err_ff;

   assign arrive = (s1_dist_ff < DIST_W'(arrive_ff))
                && (s1_vel_ff < $signed({2'b00, stop_ff}));
   assign mag     = (s1_dist_ff >= FULL_SPEED_DIST) ? FULL_SPEED
                                                    : {s1_dist_ff[MAG_W-2:0], 1'b0};
   assign desired = s1_below_ff ? $signed(ERR_W'(mag)) : -$signed(ERR_W'(mag));
   assign err     = desired - ERR_W'(s1_vel_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s1_valid_ff;
      end
      s2_mode_ff   <= s1_mode_ff;
      s2_arrive_ff <= arrive;
      s2_err_ff    <= err;
   end

   // ------------------------------------------------------------------
   // Stage 3: window shift, running sum, derivative
   // ------------------------------------------------------------------
   logic                      push, restart, full;
   logic signed [ERR_W-1:0]   tap [WINDOW_LEN];
   logic signed [ERR_W-1:0]   evicted;
   logic [FILL_W-1:0]         fill_ff, fill_in;
   logic signed [SUM_W-1:0]   sum_ff, sum_in;
   logic signed [ERR_W-1:0]   prev_ff, prev_in;
   logic                      have_prev_ff, have_prev_in;
   logic signed [DELTA_W-1:0] delta;
   logic                      s3_valid_ff;
   pidw_tag_type              s3_tag_ff, s3_tag_in;
   logic signed [ERR_W-1:0]   s3_err_ff;
   logic signed [DELTA_W-1:0] s3_delta_ff;

   assign push    = s2_valid_ff && (s2_mode_ff == MODE_TICK) && !s2_arrive_ff;
   assign restart = s2_valid_ff && (s2_mode_ff == MODE_RESTART);
   assign full    = fill_ff == FILL_W'(WINDOW_LEN);

   // newest error enters cell 0; the oldest drops out of the last cell
   for (genvar k = 0; k < WINDOW_LEN; k++) begin : g_win
      if (k == 0) begin : g_head
         pidw_cell u_cell (
            .clock    (clock),
            .shift_en (push),
            .d_in     (s2_err_ff),
            .q_out    (tap[k])
         );
      end else begin : g_body
         pidw_cell u_cell (
            .clock    (clock),
            .shift_en (push),
            .d_in     (tap[k-1]),
            .q_out    (tap[k])
         );
      end
   end

   // last cell counts only once the window has been filled since restart
   assign evicted = full ? tap[WINDOW_LEN-1] : '0;
   assign delta   = have_prev_ff ? (DELTA_W'(s2_err_ff) - DELTA_W'(prev_ff)) : '0;

   always_comb begin
      fill_in      = fill_ff;
      sum_in       = sum_ff;
      prev_in      = prev_ff;
      have_prev_in = have_prev_ff;
      if (restart) begin
         fill_in      = '0;
         sum_in       = '0;
         prev_in      = '0;
         have_prev_in = 1'b0;
      end else if (push) begin
         fill_in      = full ? fill_ff : fill_ff + 1'b1;
         sum_in       = sum_ff + SUM_W'(s2_err_ff) - SUM_W'(evicted);
         prev_in      = s2_err_ff;
         have_prev_in = 1'b1;
      end
      s3_tag_in.pass    = push;
      s3_tag_in.brake   = (s2_mode_ff == MODE_TICK) && s2_arrive_ff;
      s3_tag_in.arrived = (s2_mode_ff == MODE_TICK) && s2_arrive_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff      <= '0;
         sum_ff       <= '0;
         prev_ff      <= '0;
         have_prev_ff <= 1'b0;
         s3_valid_ff  <= 1'b0;
      end else begin
         fill_ff      <= fill_in;
         sum_ff       <= sum_in;
         prev_ff      <= prev_in;
         have_prev_ff <= have_prev_in;
         s3_valid_ff  <= s2_valid_ff;
      end
      s3_tag_ff   <= s3_tag_in;
      s3_err_ff   <= s2_err_ff;
      s3_delta_ff <= delta;
   end

   // ------------------------------------------------------------------
   // Stages 4..6: PID arithmetic (sum_ff already holds this tick's sum)
   // ------------------------------------------------------------------
   logic    mac_valid;
   rsp_type mac_rsp;

   pidw_mac #(.SUM_W(SUM_W)) u_mac (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (s3_valid_ff),
      .in_tag     (s3_tag_ff),
      .in_err     (s3_err_ff),
      .in_sum     (sum_ff),
      .in_delta   (s3_delta_ff),
      .gain_prop  (kp_ff),
      .gain_integ (ki_ff),
      .gain_deriv (kd_ff),
      .out_valid  (mac_valid),
      .out_rsp    (mac_rsp)
   );

   // ------------------------------------------------------------------
   // Response queue; occupancy bound keeps it from overflowing
   // ------------------------------------------------------------------
   rsp_type               fifo_ff [FIFO_DEPTH];
   logic [FIFO_PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [OCC_W-1:0]      cnt_ff, cnt_in;

   assign cnt_in = cnt_ff + OCC_W'(mac_valid) - OCC_W'(rsp_fire);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         if (mac_valid) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (rsp_fire) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (mac_valid) begin
         fifo_ff[wr_ptr_ff] <= mac_rsp;
      end
   end

   assign rsp_valid = cnt_ff != '0;
   assign rsp_data  = fifo_ff[rd_ptr_ff];

endmodule

/* hw/rtl/pidw_checker.sv */
// Port-level checks for the windowed PID velocity controller, bound to the top.
// Depends on pidw_pkg.
module pidw_checker
   import pidw_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_ready,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_data
);

   // queue is empty right after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid right after reset");

   // arrival means brake on and zero power
   a_arrive_stop: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.arrived |-> rsp_data.brake && (rsp_data.motor_power == '0))
      else $error("arrival response with power or without brake");

   // brake is only ever set together with arrival
   a_brake_only_arrive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.brake |-> rsp_data.arrived)
      else $error("brake without arrival");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("stalled response changed");

   a_req_ready_idle: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid && !req_valid |=> req_ready)
      else $error("request not ready while nothing is queued");

endmodule

bind windowed_pid_velocity_controller_unit pidw_checker u_pidw_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

/* test/pidw_power_checker.sv */
// Checker for the windowed PID velocity controller: watches the request,
// response and CSR ports, predicts each response and compares it.
// Depends on pidw_pkg for the payload types, CSR map and widths.
`timescale 1ns / 1ps

module pidw_power_checker
   import pidw_pkg::*;
#(
   parameter int WINDOW_LEN = 200
)
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_ready,
   input  req_type               req_data,
   input  logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  rsp_type               rsp_data,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic                  pready,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output int                    mismatches,
   output int                    in_flight
);

   // register copies
   logic [ARRIVE_W-1:0] arrive_dist;
   logic [STOP_W-1:0]   stop_vel;
   logic [GAIN_W-1:0]   kp;
   logic [GAIN_W-1:0]   ki_dt;
   logic [GAIN_W-1:0]   kd_dt;

   // PID state
   logic signed [ERR_W-1:0] err_hist [WINDOW_LEN];
   int                      slot;
   int                      filled;
   logic signed [25:0]      err_total;
   logic signed [ERR_W-1:0] last_err;
   bit                      last_valid;

   rsp_type expected_drive [$];
   int      fail_total;

   function automatic void clear_pid_state();
      slot       = 0;
      filled     = 0;
      err_total  = '0;
      last_err   = '0;
      last_valid = 1'b0;
   endfunction

   function automatic rsp_type compute_drive(req_type r);
      rsp_type res;
      int      pos, vel, tgt, car_dist, mag, want, err, evict, delta;
      longint  acc, pw;
      res = '0;
      if (r.mode == MODE_RESTART) begin
         clear_pid_state();
         return res;
      end
      pos  = int'(r.floor_pos);
      vel  = int'($signed(r.velocity));
      tgt  = int'(r.target_floor) * 4096;
      car_dist = (pos > tgt) ? pos - tgt : tgt - pos;
      // parked at the target: brake, state untouched
      if (car_dist < int'(arrive_dist) && vel < int'(stop_vel)) begin
         res.brake   = 1'b1;
         res.arrived = 1'b1;
         return res;
      end
      mag  = (car_dist >= 2048) ? 4096 : 2 * car_dist;
      want = (pos < tgt) ? mag : -mag;
      err  = want - vel;

      evict          = (filled >= WINDOW_LEN) ? int'(err_hist[slot]) : 0;
      err_total      = err_total + 26'(err - evict);
      err_hist[slot] = err[ERR_W-1:0];
      slot           = (slot + 1 >= WINDOW_LEN) ? 0 : slot + 1;
      if (filled < WINDOW_LEN)
         filled++;

      delta      = last_valid ? err - int'(last_err) : 0;
      last_err   = err[ERR_W-1:0];
      last_valid = 1'b1;

      acc = longint'(kp) * longint'(err) + longint'(ki_dt) * longint'(err_total)
          + longint'(kd_dt) * longint'(delta);
      pw = acc >>> FRAC_W;   // floor to Q.12
      if (pw > longint'(POWER_MAX))
         pw = longint'(POWER_MAX);
      if (pw < longint'(POWER_MIN))
         pw = longint'(POWER_MIN);
      res.motor_power = pw[POWER_W-1:0];
      return res;
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         arrive_dist = 12'd41;
         stop_vel    = 15'd4;
         kp          = 24'd20480;
         ki_dt       = 24'd12;
         kd_dt       = 24'd12288000;
         clear_pid_state();
         expected_drive.delete();
         fail_total  = 0;
      end else begin
         if (psel && penable && pwrite && pready) begin
            case (paddr[CSR_ADDR_W-1:2])
               REG_ARRIVE_DIST: arrive_dist = pwdata[ARRIVE_W-1:0];
               REG_STOP_VEL:    stop_vel    = pwdata[STOP_W-1:0];
               REG_GAIN_PROP:   kp          = pwdata[GAIN_W-1:0];
               REG_GAIN_INTEG:  ki_dt       = pwdata[GAIN_W-1:0];
               REG_GAIN_DERIV:  kd_dt       = pwdata[GAIN_W-1:0];
               default: ;
            endcase
         end
         // responses first: the one leaving now belongs to an older request
         if (rsp_valid && rsp_ready) begin
            if (expected_drive.size() == 0) begin
               $display("%0t: response with no request pending: power %0d brake %b arrived %b",
                        $time, rsp_data.motor_power, rsp_data.brake, rsp_data.arrived);
               fail_total++;
            end else begin
               want = expected_drive.pop_front();
               if (rsp_data.motor_power !== want.motor_power || rsp_data.brake !== want.brake
                   || rsp_data.arrived !== want.arrived) begin
                  $display("%0t: mismatch expected power %0d brake %b arrived %b, got %0d %b %b",
                           $time, want.motor_power, want.brake, want.arrived,
                           rsp_data.motor_power, rsp_data.brake, rsp_data.arrived);
                  fail_total++;
               end
            end
         end
         if (req_valid && req_ready)
            expected_drive.push_back(compute_drive(req_data));
      end
      mismatches <= fail_total;
      in_flight  <= expected_drive.size();
   end

endmodule

/* test/tb_windowed_pid_velocity_controller_unit.sv */
// Testbench top for windowed_pid_velocity_controller_unit: clock, reset,
// request/response/CSR stimulus, watchdog and verdict.
// Depends on pidw_pkg, the block and pidw_power_checker.
`timescale 1ns / 1ps

module tb_windowed_pid_velocity_controller_unit;
   import pidw_pkg::*;

   localparam int WINDOW_LEN  = 200;
   localparam int PHASE_ITEMS = 280;   // random requests per config phase
   localparam int QUIET_LIMIT = 3000;  // cycles with no handshake before giving up
   localparam int HOLD_CYCLES = 150;   // long response back-pressure

   logic                  clock     = 1'b0;
   logic                  reset     = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   req_type               req_data  = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   rsp_type               rsp_data;
   logic                  psel      = 1'b0;
   logic                  penable   = 1'b0;
   logic                  pwrite    = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr     = '0;
   logic [CSR_DATA_W-1:0] pwdata    = '0;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   int mismatches;
   int in_flight;

   // pacing knobs, changed per phase
   int send_idle_pct = 26;
   int rsp_idle_pct  = 59;
   int phase_id      = 0;
   int phase_sent    = 0;
   bit hold_rsp      = 1'b0;   // asks the receiver for one long hold-off
   int hold_left     = 0;
   int quiet_cycles  = 0;

   windowed_pid_velocity_controller_unit #(.WINDOW_LEN(WINDOW_LEN)) u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   pidw_power_checker #(.WINDOW_LEN(WINDOW_LEN)) u_checker (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data),
      .psel       (psel),
      .penable    (penable),
      .pwrite     (pwrite),
      .pready     (pready),
      .paddr      (paddr),
      .pwdata     (pwdata),
      .mismatches (mismatches),
      .in_flight  (in_flight)
   );

   // 8 ns clock
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Receiver: random ready at the falling edge; one long hold-off on request,
   // counted here so the sender keeps pushing and the response queue fills.
   always begin
      @(negedge clock);
      if (hold_rsp) begin
         hold_left = HOLD_CYCLES;
         hold_rsp  = 1'b0;
      end
      if (hold_left > 0) begin
         rsp_ready <= 1'b0;
         hold_left--;
      end else begin
         rsp_ready <= ($urandom_range(99) >= rsp_idle_pct);
      end
   end

   // Watchdog: any handshake on either channel counts as progress.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("windowed_pid_velocity_controller_unit verification failed");
         $finish;
      end
   end

   // Idling mix: receiver-heavy gaps first, then sender-heavy, then none.
   task automatic set_idle(input int p);
      send_idle_pct = (p <= 1) ? 26 : (p <= 3) ? 59 : 0;
      rsp_idle_pct  = (p <= 1) ? 59 : (p <= 3) ? 26 : 0;
   endtask

   // Drop valid and let every outstanding response drain, plus a margin.
   task automatic wait_idle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (in_flight != 0)
         @(negedge clock);
      repeat (10) @(negedge clock);
   endtask

   // APB write: setup cycle, then access cycle; pready is sampled at the edge.
   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx, input logic [31:0] value);
      @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= value;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   task automatic set_config(input logic [31:0] arrive, input logic [31:0] stop,
                             input logic [31:0] prop, input logic [31:0] integ,
                             input logic [31:0] deriv);
      csr_write(REG_ARRIVE_DIST, arrive);
      csr_write(REG_STOP_VEL, stop);
      csr_write(REG_GAIN_PROP, prop);
      csr_write(REG_GAIN_INTEG, integ);
      csr_write(REG_GAIN_DERIV, deriv);
   endtask

   // Offer one request and hold it until accepted. Valid is only ever
   // assigned once per falling edge, so back-to-back requests stay high.
   task automatic push_request(input req_type item);
      // sender pause until everything has come back, once, mid-phase
      if (phase_id == 2 && phase_sent == 100)
         wait_idle();
      if (phase_id == 4 && phase_sent == 60)
         hold_rsp = 1'b1;
      while ($urandom_range(99) < send_idle_pct) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (!req_ready);
      phase_sent++;
   endtask

   function automatic req_type make_tick(input int pos, input int vel, input int tgt);
      req_type item;
      item.mode         = MODE_TICK;
      item.floor_pos    = pos[POS_W-1:0];
      item.velocity     = vel[VEL_W-1:0];
      item.target_floor = tgt[FLOOR_W-1:0];
      return item;
   endfunction

   // Anything at all, restarts included.
   function automatic req_type noise_request();
      req_type item;
      item.mode         = 1'($urandom_range(1));
      item.floor_pos    = POS_W'($urandom);
      item.velocity     = VEL_W'($urandom);
      item.target_floor = FLOOR_W'($urandom);
      return item;
   endfunction

   // Tick with the car mostly near its target so arrival and the
   // proportional ramp both get hit; velocity mostly slow.
   function automatic req_type tick_request();
      int tgt, pos, off, vel;
      tgt = $urandom_range(15);
      case ($urandom_range(3))
         0:       off = int'($urandom_range(65535)) - tgt * 4096;
         3:       off = int'($urandom_range(64));
         default: off = int'($urandom_range(2600));
      endcase
      if ($urandom_range(1))
         off = -off;
      pos = tgt * 4096 + off;
      if (pos < 0)
         pos = 0;
      if (pos > 65535)
         pos = 65535;
      case ($urandom_range(9))
         0, 1, 2, 3, 4: vel = int'($urandom_range(128)) - 64;
         5, 6, 7:       vel = int'($urandom_range(16384)) - 8192;
         default:       vel = int'($urandom_range(65535)) - 32768;
      endcase
      return make_tick(pos, vel, tgt);
   endfunction

   // Restart followed by a run of ticks; every so often a run long enough
   // to fill the window and start evicting. Some pure noise in between.
   task automatic run_random(input int budget);
      req_type restart_item;
      int      run_len;
      bit      first;
      first = 1'b1;
      while (phase_sent < budget) begin
         if ($urandom_range(99) < 12) begin
            push_request(noise_request());
         end else begin
            restart_item      = noise_request();
            restart_item.mode = MODE_RESTART;
            push_request(restart_item);
            run_len = (first || $urandom_range(3) == 0) ? $urandom_range(260, 205)
                                                        : $urandom_range(40, 1);
            first = 1'b0;
            for (int k = 0; k < run_len && phase_sent < budget; k++)
               push_request(tick_request());
         end
      end
   endtask

   initial begin
      req_type restart_item;
      set_idle(0);
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed part, reset register values.
      push_request(make_tick(0, 0, 3));                    // tick before any restart
      restart_item = '{mode: MODE_RESTART, floor_pos: 16'hFFFF,
                       velocity: 16'sh7FFF, target_floor: 4'hF};
      push_request(restart_item);
      push_request(make_tick(3 * 4096, -32768, 3));        // arrival, fastest downward
      push_request(make_tick(3 * 4096 + 100, 0, 3));       // tick right after arrival
      push_request(make_tick(3 * 4096, 4, 3));             // at target, speed equals stop speed
      push_request(make_tick(3 * 4096 - 40, 3, 3));        // just inside arrival distance
      push_request(make_tick(3 * 4096 + 41, 3, 3));        // exactly arrival distance
      push_request(make_tick(5 * 4096 - 2048, 0, 5));      // full-speed boundary
      push_request(make_tick(5 * 4096 + 2047, 100, 5));    // just under it
      push_request(make_tick(65535, 32767, 15));           // most negative error
      push_request(make_tick(0, -32768, 15));              // most positive error
      push_request(make_tick(65535, -32768, 0));
      push_request(make_tick(0, 32767, 0));                // at target but moving too fast
      restart_item = '{mode: MODE_RESTART, floor_pos: 16'h0,
                       velocity: 16'sh0, target_floor: 4'h0};
      push_request(restart_item);
      push_request(make_tick(8 * 4096, 1000, 7));          // first tick: no derivative
      push_request(make_tick(8 * 4096, -1000, 7));

      for (int p = 1; p <= 5; p++) begin
         wait_idle();
         phase_id   = p;
         phase_sent = 0;
         set_idle(p);
         case (p)
            1: set_config(32'h0, 32'h0, 32'h0, 32'h0, 32'h0);
            2: set_config(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                          32'hFFFF_FFFF, 32'hFFFF_FFFF);
            3: set_config($urandom, $urandom, $urandom, $urandom, $urandom);
            4: set_config($urandom_range(4095), $urandom_range(32767),
                          $urandom_range(65536), $urandom_range(255),
                          $urandom_range(1 << 20));
            default: set_config(32'd41, 32'd4, 32'd20480, 32'd12, 32'd12288000);
         endcase
         run_random(PHASE_ITEMS);
      end

      wait_idle();
      repeat (20) @(posedge clock);
      if (mismatches == 0)
         $display("windowed_pid_velocity_controller_unit verification clean");
      else
         $display("windowed_pid_velocity_controller_unit verification failed");
      $finish;
   end

endmodule
